// ----- design/etpq_pkg.sv -----
// Shared codes, defaults and cell control type for the event-time priority queue.
// Depends on nothing; imported by etpq_cell and event_time_priority_queue.
`default_nettype none

package etpq_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 64;
   localparam int unsigned TIME_BITS_DEF   = 32;
   localparam int unsigned ID_BITS_DEF     = 16;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_POP    = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic       match_load;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- design/etpq_cell.sv -----
// One slot of the sorted event chain: holds a valid bit, time and id, and a match flag.
// Depends on etpq_pkg; trades contents with its left and right neighbors.
`default_nettype none

module etpq_cell #(
   parameter int unsigned TIME_BITS = etpq_pkg::TIME_BITS_DEF,
   parameter int unsigned ID_BITS   = etpq_pkg::ID_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  etpq_pkg::cell_ctrl_type   ctrl,
   input  logic                      remove_here,
   input  logic [TIME_BITS-1:0]      ins_time,
   input  logic [ID_BITS-1:0]        ins_id,
   input  logic                      left_le,
   input  logic                      left_valid,
   input  logic [TIME_BITS-1:0]      left_time,
   input  logic [ID_BITS-1:0]        left_id,
   input  logic                      right_valid,
   input  logic [TIME_BITS-1:0]      right_time,
   input  logic [ID_BITS-1:0]        right_id,
   output logic                      le,
   output logic                      slot_valid,
   output logic [TIME_BITS-1:0]      slot_time,
   output logic [ID_BITS-1:0]        slot_id,
   output logic [TIME_BITS-1:0]      next_time,
   output logic                      match
);
   import etpq_pkg::*;

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic                 match_ff, match_in;

   assign le = valid_ff && (time_ff <= ins_time);

   always_comb begin
      valid_in = valid_ff;
      time_in  = time_ff;
      id_in    = id_ff;
      unique case (ctrl.op)
         CELL_INSERT: begin
            if (!le) begin
               if (left_le) begin
                  valid_in = 1'b1;
                  time_in  = ins_time;
                  id_in    = ins_id;
               end else begin
                  valid_in = left_valid;
                  time_in  = left_time;
                  id_in    = left_id;
               end
            end
         end
         CELL_REMOVE: begin
            if (remove_here) begin
               valid_in = right_valid;
               time_in  = right_time;
               id_in    = right_id;
            end
         end
         default: begin
         end
      endcase
      match_in = ctrl.match_load ? (valid_ff && (id_ff == ins_id)) : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
      time_ff <= time_in;
      id_ff   <= id_in;
   end

   assign slot_valid = valid_ff;
   assign slot_time  = time_ff;
   assign slot_id    = id_ff;
   assign next_time  = time_in;
   assign match      = match_ff;

endmodule

`default_nettype wire

// ----- design/event_time_priority_queue.sv -----
// Event-time priority queue: a chain of etpq_cell slots kept sorted by time, plus control.
// Depends on etpq_pkg and etpq_cell.
//
// Usage: an item on the req_ channel (req_func, req_event_id, req_event_time) transfers
// when req_valid is high and req_stall is low. req_func selects insert, pop earliest or
// delete by id. Every item yields exactly one transfer on the rsp_ channel carrying the
// status, the popped event, the head time and the entry count after the operation.
// For insert, pop and the unused code the result is registered at the accepting edge and
// shows the next cycle. Delete first registers an id match in every cell, then removes
// the earliest match, with the slot chain shifting one place toward the head. Throughput
// is one item per cycle for insert and pop unless rsp_stall holds a result; a delete
// keeps req_stall high until its removal is done. Equal times leave in first-in order. A
// full queue drops an insert and reports it. A synchronous reset empties the queue; slot
// contents are not cleared. While rsp_stall holds a pending result, req_stall stays high
// and the queue does not change.
`default_nettype none

module event_time_priority_queue #(
   parameter int unsigned QUEUE_DEPTH = etpq_pkg::QUEUE_DEPTH_DEF,
   parameter int unsigned TIME_BITS   = etpq_pkg::TIME_BITS_DEF,
   parameter int unsigned ID_BITS     = etpq_pkg::ID_BITS_DEF,
   parameter int unsigned CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [ID_BITS-1:0]   req_event_id,
   input  logic [TIME_BITS-1:0] req_event_time,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [ID_BITS-1:0]   rsp_popped_id,
   output logic [TIME_BITS-1:0] rsp_popped_time,
   output logic                 rsp_head_valid,
   output logic [TIME_BITS-1:0] rsp_head_time,
   output logic [CNT_BITS-1:0]  rsp_entry_count
);
   import etpq_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_DELETE = 1'b1;

   logic                   state_ff, state_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic [ID_BITS-1:0]     popped_id_ff, popped_id_in;
   logic [TIME_BITS-1:0]   popped_time_ff, popped_time_in;
   logic                   head_valid_ff, head_valid_in;
   logic [TIME_BITS-1:0]   head_time_ff, head_time_in;
   logic [CNT_BITS-1:0]    entry_count_ff;

   cell_ctrl_type          ctrl;
   logic                   out_free;
   logic                   accept;
   logic                   rsp_load;
   logic                   full;
   logic [QUEUE_DEPTH-1:0] le_vec, valid_vec, match_vec, remove_vec, found_vec;
   logic [TIME_BITS-1:0]   time_arr [QUEUE_DEPTH];
   logic [TIME_BITS-1:0]   next_time_arr [QUEUE_DEPTH];
   logic [ID_BITS-1:0]     id_arr [QUEUE_DEPTH];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                 left_le, left_valid, right_valid;
      logic [TIME_BITS-1:0] left_time, right_time;
      logic [ID_BITS-1:0]   left_id, right_id;

      if (g == 0) begin : g_head
         assign left_le    = 1'b1;
         assign left_valid = 1'b0;
         assign left_time  = '0;
         assign left_id    = '0;
      end else begin : g_body
         assign left_le    = le_vec[g-1];
         assign left_valid = valid_vec[g-1];
         assign left_time  = time_arr[g-1];
         assign left_id    = id_arr[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_time  = '0;
         assign right_id    = '0;
      end else begin : g_inner
         assign right_valid = valid_vec[g+1];
         assign right_time  = time_arr[g+1];
         assign right_id    = id_arr[g+1];
      end

      etpq_cell #(
         .TIME_BITS (TIME_BITS),
         .ID_BITS   (ID_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .remove_here (remove_vec[g]),
         .ins_time    (req_event_time),
         .ins_id      (req_event_id),
         .left_le     (left_le),
         .left_valid  (left_valid),
         .left_time   (left_time),
         .left_id     (left_id),
         .right_valid (right_valid),
         .right_time  (right_time),
         .right_id    (right_id),
         .le          (le_vec[g]),
         .slot_valid  (valid_vec[g]),
         .slot_time   (time_arr[g]),
         .slot_id     (id_arr[g]),
         .next_time   (next_time_arr[g]),
         .match       (match_vec[g])
      );
   end

   always_comb begin
      found_vec = match_vec;
      for (int s = 1; s < QUEUE_DEPTH; s = s * 2) begin
         found_vec = found_vec | (found_vec << s);
      end
   end

   always_comb begin
      ctrl.op         = CELL_HOLD;
      ctrl.match_load = 1'b0;
      remove_vec      = '0;
      count_in        = count_ff;
      state_in        = state_ff;
      rsp_load        = 1'b0;
      status_in       = STATUS_OK;
      popped_id_in    = '0;
      popped_time_in  = '0;
      if (state_ff == ST_IDLE) begin
         if (accept) begin
            unique case (req_func)
               FUNC_INSERT: begin
                  rsp_load = 1'b1;
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     ctrl.op  = CELL_INSERT;
                     count_in = count_ff + CNT_BITS'(1);
                  end
               end
               FUNC_POP: begin
                  rsp_load = 1'b1;
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     ctrl.op        = CELL_REMOVE;
                     remove_vec     = '1;
                     count_in       = count_ff - CNT_BITS'(1);
                     popped_id_in   = id_arr[0];
                     popped_time_in = time_arr[0];
                  end
               end
               FUNC_DELETE: begin
                  ctrl.match_load = 1'b1;
                  state_in        = ST_DELETE;
               end
               default: begin
                  rsp_load = 1'b1;
               end
            endcase
         end
      end else begin
         if (out_free) begin
            rsp_load = 1'b1;
            state_in = ST_IDLE;
            if (|match_vec) begin
               ctrl.op    = CELL_REMOVE;
               remove_vec = found_vec;
               count_in   = count_ff - CNT_BITS'(1);
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
      end
      head_valid_in = (count_in != '0);
      head_time_in  = head_valid_in ? next_time_arr[0] : '0;
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         status_ff      <= status_in;
         popped_id_ff   <= popped_id_in;
         popped_time_ff <= popped_time_in;
         head_valid_ff  <= head_valid_in;
         head_time_ff   <= head_time_in;
         entry_count_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_popped_id   = popped_id_ff;
   assign rsp_popped_time = popped_time_ff;
   assign rsp_head_valid  = head_valid_ff;
   assign rsp_head_time   = head_time_ff;
   assign rsp_entry_count = entry_count_ff;

   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("valid slots disagree with entry count");

   assert property (@(posedge clock) disable iff (reset)
      valid_vec[1] |-> (time_arr[0] <= time_arr[1]))
      else $error("head slot out of time order");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_INSERT) && !full)
         |=> (count_ff == $past(count_ff) + CNT_BITS'(1)))
      else $error("insert did not grow the queue");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DELETE) && out_free && (match_vec == '0))
         |=> (rsp_valid && (rsp_status == STATUS_NOT_FOUND)))
      else $error("missing not-found status on delete");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for event_time_priority_queue: directed then random insert, pop
// and delete traffic with random gaps and stalls, checked against a queue-order predictor.
// Depends on etpq_pkg and the event_time_priority_queue RTL.

module testbench;
   import etpq_pkg::*;

   localparam int unsigned DEPTH          = QUEUE_DEPTH_DEF;
   localparam int unsigned TIME_W         = TIME_BITS_DEF;
   localparam int unsigned ID_W           = ID_BITS_DEF;
   localparam int unsigned CNT_W          = $clog2(DEPTH + 1);
   localparam logic [1:0]  FUNC_NOP       = 2'd3;
   localparam int unsigned RANDOM_ITEMS   = 600;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 10;
   localparam int unsigned MAX_PHASE      = 150;

   typedef struct packed {
      logic [1:0]        status;
      logic [ID_W-1:0]   popped_id;
      logic [TIME_W-1:0] popped_time;
      logic              head_valid;
      logic [TIME_W-1:0] head_time;
      logic [CNT_W-1:0]  entry_count;
   } queue_report_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] stamp;
   } queued_event_type;

   typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED, PHASE_DELETE} phase_kind_type;

   class event_queue_scoreboard;
      queued_event_type event_list[$];
      queue_report_type expected_reports[$];
      int unsigned      errors;

      function new();
         errors = 0;
      endfunction

      function int unsigned occupancy();
         return event_list.size();
      endfunction

      function int unsigned outstanding();
         return expected_reports.size();
      endfunction

      function logic [ID_W-1:0] queued_id();
         return event_list[$urandom_range(0, event_list.size() - 1)].id;
      endfunction

      function void note_request(logic [1:0] func, logic [ID_W-1:0] id,
                                 logic [TIME_W-1:0] stamp);
         queue_report_type rpt;
         queued_event_type ev;
         int               pos;
         rpt = '0;
         rpt.status = STATUS_OK;
         case (func)
            FUNC_INSERT: begin
               if (event_list.size() >= DEPTH) begin
                  rpt.status = STATUS_FULL;
               end else begin
                  pos = 0;
                  while (pos < event_list.size() && event_list[pos].stamp <= stamp) pos++;
                  ev.id = id;
                  ev.stamp = stamp;
                  event_list.insert(pos, ev);
               end
            end
            FUNC_POP: begin
               if (event_list.size() == 0) begin
                  rpt.status = STATUS_EMPTY;
               end else begin
                  ev = event_list.pop_front();
                  rpt.popped_id = ev.id;
                  rpt.popped_time = ev.stamp;
               end
            end
            FUNC_DELETE: begin
               pos = 0;
               while (pos < event_list.size() && event_list[pos].id != id) pos++;
               if (pos >= event_list.size()) begin
                  rpt.status = STATUS_NOT_FOUND;
               end else begin
                  event_list.delete(pos);
               end
            end
            default: begin
            end
         endcase
         rpt.head_valid = (event_list.size() != 0);
         if (event_list.size() != 0) begin
            rpt.head_time = event_list[0].stamp;
         end
         rpt.entry_count = CNT_W'(event_list.size());
         expected_reports.push_back(rpt);
      endfunction

      function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_report(queue_report_type act);
         queue_report_type exp_r;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, act);
            errors++;
            return;
         end
         exp_r = expected_reports.pop_front();
         compare_field("status", 64'(exp_r.status), 64'(act.status));
         compare_field("popped_id", 64'(exp_r.popped_id), 64'(act.popped_id));
         compare_field("popped_time", 64'(exp_r.popped_time), 64'(act.popped_time));
         compare_field("head_valid", 64'(exp_r.head_valid), 64'(act.head_valid));
         compare_field("head_time", 64'(exp_r.head_time), 64'(act.head_time));
         compare_field("entry_count", 64'(exp_r.entry_count), 64'(act.entry_count));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_func = FUNC_NOP;
   logic [ID_W-1:0]   req_event_id = '0;
   logic [TIME_W-1:0] req_event_time = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [ID_W-1:0]   rsp_popped_id;
   logic [TIME_W-1:0] rsp_popped_time;
   logic              rsp_head_valid;
   logic [TIME_W-1:0] rsp_head_time;
   logic [CNT_W-1:0]  rsp_entry_count;

   event_queue_scoreboard sb = new();

   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_cycle = 0;
   int unsigned quiet_cycles = 0;
   int unsigned roll = 0;

   event_time_priority_queue u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_event_id    (req_event_id),
      .req_event_time  (req_event_time),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_popped_id   (rsp_popped_id),
      .rsp_popped_time (rsp_popped_time),
      .rsp_head_valid  (rsp_head_valid),
      .rsp_head_time   (rsp_head_time),
      .rsp_entry_count (rsp_entry_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_func, req_event_id, req_event_time);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_report({rsp_status, rsp_popped_id, rsp_popped_time, rsp_head_valid,
                             rsp_head_time, rsp_entry_count});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      rsp_cycle++;
      if (rsp_cycle % 300 == 0) begin
         rsp_quiet = ($urandom_range(0, 3) == 0);
      end
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left--;
      end else if (rsp_quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            rsp_stall <= 1'b0;
         end else if (roll < 93) begin
            rsp_stall <= 1'b1;
            rsp_hold_left = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            rsp_hold_left = $urandom_range(10, 40);
         end
      end
   end

   function automatic int unsigned pick_gap(bit quiet);
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [TIME_W-1:0] pick_time();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 15);
      if (r < 45) return '1;
      if (r < 50) return '0;
      return $urandom;
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return ID_W'($urandom_range(0, 15));
      if (r < 53) return '1;
      if (r < 56) return '0;
      return ID_W'($urandom_range(0, 65535));
   endfunction

   task automatic transfer_request(input logic [1:0] func, input logic [ID_W-1:0] id,
                                   input logic [TIME_W-1:0] stamp);
      int unsigned gap;
      req_func <= func;
      req_event_id <= id;
      req_event_time <= stamp;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      phase_kind_type    kind;
      int unsigned       items_sent;
      int unsigned       phase_items;
      int unsigned       phase_len;
      int unsigned       limit_hits;
      int unsigned       w_ins;
      int unsigned       w_pop;
      int unsigned       r;
      bit                phase_done;
      bit                first_phase;
      logic [1:0]        func;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] stamp;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      transfer_request(FUNC_POP, 16'h1234, 32'hDEAD_BEEF);
      transfer_request(FUNC_DELETE, 16'd5, '0);
      transfer_request(FUNC_NOP, '1, '1);
      transfer_request(FUNC_INSERT, '1, '1);
      transfer_request(FUNC_INSERT, '0, '0);
      transfer_request(FUNC_INSERT, 16'd1, 32'd100);
      transfer_request(FUNC_INSERT, 16'd2, 32'd100);
      transfer_request(FUNC_INSERT, 16'd3, 32'd100);
      transfer_request(FUNC_INSERT, 16'd1, 32'd50);
      transfer_request(FUNC_DELETE, 16'd1, '1);
      transfer_request(FUNC_NOP, 16'd7, 32'd7);
      transfer_request(FUNC_POP, '0, '0);
      transfer_request(FUNC_POP, '0, '0);
      transfer_request(FUNC_DELETE, 16'd7, '0);
      transfer_request(FUNC_POP, '1, '1);
      transfer_request(FUNC_POP, '0, '0);
      transfer_request(FUNC_POP, '0, '0);
      transfer_request(FUNC_POP, '0, '0);
      transfer_request(FUNC_DELETE, '1, '0);

      items_sent = 0;
      first_phase = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         kind = first_phase ? PHASE_FILL : phase_kind_type'($urandom_range(0, 3));
         first_phase = 1'b0;
         req_quiet = ($urandom_range(0, 4) == 0);
         phase_len = $urandom_range(30, 80);
         phase_items = 0;
         limit_hits = 0;
         case (kind)
            PHASE_FILL: begin
               w_ins = 85;
               w_pop = 6;
            end
            PHASE_DRAIN: begin
               w_ins = 10;
               w_pop = 78;
            end
            PHASE_MIXED: begin
               w_ins = 40;
               w_pop = 30;
            end
            default: begin
               w_ins = 30;
               w_pop = 12;
            end
         endcase
         phase_done = 1'b0;
         while (!phase_done) begin
            r = $urandom_range(0, 99);
            if (r < w_ins) func = FUNC_INSERT;
            else if (r < w_ins + w_pop) func = FUNC_POP;
            else if (r < 97) func = FUNC_DELETE;
            else func = FUNC_NOP;
            if ((func == FUNC_INSERT && sb.occupancy() >= DEPTH) ||
                (func == FUNC_POP && sb.occupancy() == 0)) begin
               limit_hits++;
            end
            if (func == FUNC_DELETE && sb.occupancy() > 0 && $urandom_range(0, 99) < 70) begin
               id = sb.queued_id();
            end else begin
               id = pick_id();
            end
            stamp = pick_time();
            transfer_request(func, id, stamp);
            phase_items++;
            items_sent++;
            case (kind)
               PHASE_FILL:  phase_done = (limit_hits >= 3);
               PHASE_DRAIN: phase_done = (limit_hits >= 2);
               default:     phase_done = (phase_items >= phase_len);
            endcase
            if (phase_items >= MAX_PHASE) phase_done = 1'b1;
            if (items_sent >= RANDOM_ITEMS) phase_done = 1'b1;
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
